### sv/dham_pkg.sv
`timescale 1ns / 1ps

package dham_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_TRANSLATE  = 2'd0;
    localparam logic [1:0] OP_WRITE_SEG  = 2'd1;
    localparam logic [1:0] OP_WRITE_CORE = 2'd2;

    // Kind of mapping that produced a result.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_LOCAL = 2'd1;
    localparam logic [1:0] KIND_SEG   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_ROW = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_COL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGS       = 3'd4;

    // Field widths fixed by the transaction format.
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned HOST_W   = 64;
    localparam int unsigned CORE_W   = 3;
    localparam int unsigned SLOT_W   = 2;
    localparam int unsigned MESH_W   = 6;
    localparam int unsigned OFFSET_W = 20;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_kind;

endpackage

### sv/device_to_host_address_map_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+----------------------------------------
// in       | into unit | i_in_valid / o_in_stall | opcode, core row/col, address, segment
// out      | from unit | o_out_valid / i_out_stall | host address, hit kind
// cfg      | into unit | i_cfg_valid / o_cfg_ready | register index, write data
//
// A table write is done when it is accepted; a translation runs as a core table read,
// then segment compare and selection, then the 64-bit host add into the output register.
// The core base table is a single-port-read RAM with a registered read port.
// Reset is synchronous and active low; it clears control and configuration only.
// A stalled result holds in the output register; the next transaction can still be
// taken while it waits, and a finished translation waits until that register frees.

module device_to_host_address_map_unit #(
    parameter int NUM_SEGMENTS = 4,
    parameter int MAX_ROWS     = 8,
    parameter int MAX_COLS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dham_pkg::t_opcode                 i_in_opcode,
    input  logic [dham_pkg::CORE_W-1:0]       i_in_core_row,
    input  logic [dham_pkg::CORE_W-1:0]       i_in_core_col,
    input  logic [dham_pkg::ADDR_W-1:0]       i_in_device_address,
    input  logic [dham_pkg::SLOT_W-1:0]       i_in_segment_slot,
    input  logic [dham_pkg::ADDR_W-1:0]       i_in_segment_device_base,
    input  logic [dham_pkg::ADDR_W-1:0]       i_in_segment_length,
    input  logic [dham_pkg::HOST_W-1:0]       i_in_host_base_value,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dham_pkg::HOST_W-1:0]       o_out_host_address,
    output dham_pkg::t_kind                   o_out_hit_kind,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dham_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dham_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import dham_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SEG_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_ADD
    } t_state;

    // Translation request held while the lookup runs.
    typedef struct packed {
        logic              addr_zero;
        logic              is_local;
        logic              local_ok;
        logic              other_ok;
        logic [ADDR_W-1:0] addr;
    } t_item;

    t_state               r_state;
    t_item                r_item;
    t_item                n_item;
    logic [HOST_W-1:0]    r_base;
    logic [ADDR_W-1:0]    r_off;
    t_kind                r_kind;
    logic                 r_out_valid;
    logic [HOST_W-1:0]    r_host;
    t_kind                r_out_kind;

    logic [MESH_W-1:0]    r_origin_row;
    logic [MESH_W-1:0]    r_origin_col;
    logic [3:0]           r_group_rows;
    logic [3:0]           r_group_cols;
    logic [2:0]           r_segs_in_use;

    logic [ADDR_W-1:0]    r_seg_dev_base  [NUM_SEGMENTS];
    logic [ADDR_W-1:0]    r_seg_size      [NUM_SEGMENTS];
    logic [HOST_W-1:0]    r_seg_host_base [NUM_SEGMENTS];

    logic                 in_accept;
    logic                 out_free;
    logic [MESH_W-1:0]    cid_row;
    logic [MESH_W-1:0]    cid_col;
    logic [MESH_W-1:0]    rel_row;
    logic [MESH_W-1:0]    rel_col;
    logic [IDX_W-1:0]     local_idx;
    logic [IDX_W-1:0]     other_idx;
    logic                 slot_ok;
    logic [SEG_W-1:0]     slot_idx;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [HOST_W-1:0]    ram_rdata;

    logic [ADDR_W:0]      seg_end [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] seg_hit;
    logic                 seg_any;
    logic [HOST_W-1:0]    seg_base;
    logic [ADDR_W-1:0]    seg_off;
    logic [HOST_W-1:0]    n_base;
    logic [ADDR_W-1:0]    n_off;
    t_kind                n_kind;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Core id fields of a remote address, relative to the workgroup origin.
    assign cid_row = i_in_device_address[ADDR_W-1 -: MESH_W];
    assign cid_col = i_in_device_address[ADDR_W-MESH_W-1 -: MESH_W];
    assign rel_row = cid_row - r_origin_row;
    assign rel_col = cid_col - r_origin_col;

    assign local_idx = IDX_W'(int'(i_in_core_row) * MAX_COLS + int'(i_in_core_col));
    assign other_idx = IDX_W'(int'(rel_row) * MAX_COLS + int'(rel_col));

    // Classify the incoming request before the table read.
    always_comb begin
        n_item.addr      = i_in_device_address;
        n_item.addr_zero = (i_in_device_address == '0);
        n_item.is_local  = (i_in_device_address[ADDR_W-1:OFFSET_W] == '0);
        n_item.local_ok  = ({4'b0, i_in_core_row} < 7'(MAX_ROWS))
                        && ({4'b0, i_in_core_col} < 7'(MAX_COLS));
        n_item.other_ok  = (cid_row >= r_origin_row) && (cid_col >= r_origin_col)
                        && (rel_row < {2'b0, r_group_rows})
                        && (rel_col < {2'b0, r_group_cols})
                        && ({1'b0, rel_row} < 7'(MAX_ROWS))
                        && ({1'b0, rel_col} < 7'(MAX_COLS));
    end

    assign slot_ok  = ({3'b0, i_in_segment_slot} < 5'(NUM_SEGMENTS));
    assign slot_idx = SEG_W'({3'b0, i_in_segment_slot});

    // Core base table: writes and lookups share the core index decode.
    assign ram_we    = in_accept && (i_in_opcode == OP_WRITE_CORE) && n_item.local_ok;
    assign ram_re    = in_accept && (i_in_opcode == OP_TRANSLATE);
    assign ram_raddr = n_item.is_local ? local_idx : other_idx;

    dham_ram #(
        .WIDTH (HOST_W),
        .DEPTH (CELLS)
    ) u_core_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (local_idx),
        .i_wdata (i_in_host_base_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Segment table entries are loaded by segment write transactions.
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_in_opcode == OP_WRITE_SEG) && slot_ok) begin
            r_seg_dev_base[slot_idx]  <= i_in_segment_device_base;
            r_seg_size[slot_idx]      <= i_in_segment_length;
            r_seg_host_base[slot_idx] <= i_in_host_base_value;
        end
    end

    // All active segments are compared at once; the range end does not wrap.
    always_comb begin
        for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_end[i] = {1'b0, r_seg_dev_base[i]} + {1'b0, r_seg_size[i]};
            seg_hit[i] = (5'(i) < {2'b0, r_segs_in_use})
                      && (r_item.addr >= r_seg_dev_base[i])
                      && ({1'b0, r_item.addr} < seg_end[i]);
        end
    end

    // The highest numbered hit wins.
    always_comb begin
        seg_any  = 1'b0;
        seg_base = '0;
        seg_off  = '0;
        for (int i = 0; i < NUM_SEGMENTS; i++) begin
            if (seg_hit[i]) begin
                seg_any  = 1'b1;
                seg_base = r_seg_host_base[i];
                seg_off  = r_item.addr - r_seg_dev_base[i];
            end
        end
    end

    // Pick the base and offset that the final add combines.
    always_comb begin
        n_kind = KIND_NONE;
        n_base = '0;
        n_off  = '0;
        if (r_item.addr_zero) begin
            n_kind = KIND_NONE;
        end else if (r_item.is_local) begin
            if (r_item.local_ok) begin
                n_kind = KIND_LOCAL;
                n_base = ram_rdata;
                n_off  = r_item.addr;
            end
        end else if (seg_any) begin
            n_kind = KIND_SEG;
            n_base = seg_base;
            n_off  = seg_off;
        end else if (r_item.other_ok) begin
            n_kind = KIND_OTHER;
            n_base = ram_rdata;
            n_off  = {{(ADDR_W-OFFSET_W){1'b0}}, r_item.addr[OFFSET_W-1:0]};
        end
    end

    // Sequencer, lookup registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills from the add stage and empties when taken.
            if ((r_state == S_ADD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_in_opcode == OP_TRANSLATE)) begin
                        r_item  <= n_item;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_base  <= n_base;
                    r_off   <= n_off;
                    r_kind  <= n_kind;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (out_free) begin
                        r_host     <= r_base + {{(HOST_W-ADDR_W){1'b0}}, r_off};
                        r_out_kind <= r_kind;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_row  <= '0;
            r_origin_col  <= '0;
            r_group_rows  <= '0;
            r_group_cols  <= '0;
            r_segs_in_use <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_ROW: r_origin_row  <= i_cfg_data;
                CFG_ORIGIN_COL: r_origin_col  <= i_cfg_data;
                CFG_ROWS:       r_group_rows  <= i_cfg_data[3:0];
                CFG_COLS:       r_group_cols  <= i_cfg_data[3:0];
                CFG_SEGS:       r_segs_in_use <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_host_address = r_host;
    assign o_out_hit_kind     = r_out_kind;

endmodule

### sv/dham_ram.sv
`timescale 1ns / 1ps

module dham_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dham_checker.sv
`timescale 1ns / 1ps

module dham_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input dham_pkg::t_opcode                 i_in_opcode,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [dham_pkg::HOST_W-1:0]       o_out_host_address,
    input dham_pkg::t_kind                   o_out_hit_kind
);

    import dham_pkg::*;

    // A translation occupies the unit for the following cycle.
    a_translate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_opcode == OP_TRANSLATE)) |=> o_in_stall)
        else $error("input not stalled after a translation transaction");

    // Table writes never produce a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_opcode != OP_TRANSLATE) && !o_out_valid)
        |=> !o_out_valid)
        else $error("result appeared after a write transaction");

    // An unmapped result always carries a zero host address.
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_hit_kind == KIND_NONE)) |-> (o_out_host_address == '0))
        else $error("unmapped result with nonzero host address");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_out_host_address) && $stable(o_out_hit_kind)))
        else $error("stalled result changed");

endmodule

bind device_to_host_address_map_unit dham_checker u_dham_checker (.*);
